FILE: hdl/assert_macros.svh
// Assertion macros used by the saturator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SHX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SHX_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/shx_pkg.sv
// Shared types, constants and fixed-point helpers of the harmonic saturator.
package shx_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int OUT_W            = 22;
    localparam int W_W              = 17;
    localparam int ACC_W            = 72;
    localparam int OPA_W            = 36;
    localparam int OPB_W            = 32;
    localparam int DIGIT_W          = 8;
    localparam int NDIG             = OPB_W / DIGIT_W;
    localparam int CFG_W            = 24;
    localparam int PADDR_W          = 5;
    localparam int N_REGS           = 7;

    localparam logic [W_W-1:0] W_ONE = 17'd65536;

    localparam logic signed [OPB_W-1:0] K_T   = 32'sd2995931;
    localparam logic signed [OPB_W-1:0] K_LIN = 32'sd4512289;
    localparam logic signed [OPB_W-1:0] K_3A  = 32'sd1948110;
    localparam logic signed [OPB_W-1:0] K_3B  = 32'sd1461083;
    localparam logic signed [OPB_W-1:0] K_5A  = 32'sd1439651;
    localparam logic signed [OPB_W-1:0] K_5B  = 32'sd1799564;
    localparam logic signed [OPB_W-1:0] K_5C  = 32'sd449891;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_B0    = 3'd0;
    localparam logic [2:0] REG_B1    = 3'd1;
    localparam logic [2:0] REG_A1    = 3'd2;
    localparam logic [2:0] REG_A2    = 3'd3;
    localparam logic [2:0] REG_COMB  = 3'd4;
    localparam logic [2:0] REG_GAIN  = 3'd5;
    localparam logic [2:0] REG_SCALE = 3'd6;

    localparam logic signed [CFG_W-1:0] RST_B0    = 24'sd743400;
    localparam logic signed [CFG_W-1:0] RST_B1    = 24'sd1066912;
    localparam logic signed [CFG_W-1:0] RST_A1    = -24'sd2973590;
    localparam logic signed [CFG_W-1:0] RST_A2    = 24'sd913060;
    localparam logic signed [CFG_W-1:0] RST_COMB  = 24'sd2694637;
    localparam logic signed [CFG_W-1:0] RST_GAIN  = 24'sd440402;
    localparam logic signed [CFG_W-1:0] RST_SCALE = 24'sd4609921;

    localparam logic [5:0] N_GLIDE   = 6'd4;
    localparam logic [5:0] R_BASE    = 6'd24;
    localparam logic [5:0] LAST_STEP = 6'd43;

    typedef struct packed {
        logic signed [CFG_W-1:0] b0;
        logic signed [CFG_W-1:0] b1;
        logic signed [CFG_W-1:0] a1;
        logic signed [CFG_W-1:0] a2;
        logic signed [CFG_W-1:0] comb;
        logic signed [CFG_W-1:0] gain;
        logic signed [CFG_W-1:0] scale;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic neg;
    } mac_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_T, OP_T2, OP_T3, OP_T5,
        OP_H3A, OP_H3B,
        OP_H5A, OP_H5B, OP_H5C,
        OP_LIN, OP_W3, OP_W5,
        OP_COMB,
        OP_BP0, OP_BP1, OP_BP2, OP_BP3, OP_BP4,
        OP_GAIN, OP_SCALE
    } op_t;

    // Round half up, then drop s fraction bits
    function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] v,
                                                      input int s);
        logic signed [ACC_W-1:0] half;
        half = 72'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -72'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > 72'sd1101004)
            r = 22'sd1101004;
        else if (v < -72'sd1101005)
            r = -22'sd1101005;
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

FILE: hdl/shx_mac.sv
// Digit-serial multiply-accumulate unit: one 8-bit digit of operand b per cycle.
module shx_mac
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  shx_pkg::mac_cmd_t                   cmd,
    input  logic signed [shx_pkg::OPA_W-1:0]    a,
    input  logic signed [shx_pkg::OPB_W-1:0]    b,
    output logic                                busy,
    output logic signed [shx_pkg::ACC_W-1:0]    acc
);

    logic signed [shx_pkg::OPA_W-1:0] a_reg;
    logic        [shx_pkg::OPB_W-1:0] b_reg;
    logic        [1:0]                dig_reg;
    logic                             busy_reg;
    logic signed [shx_pkg::ACC_W-1:0] acc_reg;

    logic signed [shx_pkg::DIGIT_W:0]              digit;
    logic signed [shx_pkg::OPA_W+shx_pkg::DIGIT_W:0] pp;
    logic signed [shx_pkg::ACC_W-1:0]              pp_shift;

    // Lower digits are unsigned, the top digit carries the sign
    always_comb
    begin
        if (dig_reg == 2'(shx_pkg::NDIG - 1))
            digit = {b_reg[shx_pkg::DIGIT_W-1], b_reg[shx_pkg::DIGIT_W-1:0]};
        else
            digit = {1'b0, b_reg[shx_pkg::DIGIT_W-1:0]};
        pp       = a_reg * digit;
        pp_shift = shx_pkg::ACC_W'(pp) <<< {dig_reg, 3'b000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            dig_reg  <= 2'd0;
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
        end
        else if (cmd.start)
        begin
            a_reg    <= cmd.neg ? -a : a;
            b_reg    <= b;
            dig_reg  <= 2'd0;
            busy_reg <= 1'b1;
            if (cmd.clear)
                acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_shift;
            b_reg   <= b_reg >> shx_pkg::DIGIT_W;
            dig_reg <= dig_reg + 2'd1;
            if (dig_reg == 2'(shx_pkg::NDIG - 1))
                busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

FILE: hdl/shx_apb.sv
// APB register file holding the filter and gain coefficients.
module shx_apb
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shx_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output shx_pkg::cfg_t                 cfg
);

    shx_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic signed [shx_pkg::CFG_W-1:0] wval;
    logic signed [shx_pkg::CFG_W-1:0] rval;

    assign idx    = paddr[4:2];
    assign wval   = pwdata[shx_pkg::CFG_W-1:0];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.b0    <= shx_pkg::RST_B0;
            cfg_reg.b1    <= shx_pkg::RST_B1;
            cfg_reg.a1    <= shx_pkg::RST_A1;
            cfg_reg.a2    <= shx_pkg::RST_A2;
            cfg_reg.comb  <= shx_pkg::RST_COMB;
            cfg_reg.gain  <= shx_pkg::RST_GAIN;
            cfg_reg.scale <= shx_pkg::RST_SCALE;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                shx_pkg::REG_B0:    cfg_reg.b0    <= wval;
                shx_pkg::REG_B1:    cfg_reg.b1    <= wval;
                shx_pkg::REG_A1:    cfg_reg.a1    <= wval;
                shx_pkg::REG_A2:    cfg_reg.a2    <= wval;
                shx_pkg::REG_COMB:  cfg_reg.comb  <= wval;
                shx_pkg::REG_GAIN:  cfg_reg.gain  <= wval;
                shx_pkg::REG_SCALE: cfg_reg.scale <= wval;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            shx_pkg::REG_B0:    rval = cfg_reg.b0;
            shx_pkg::REG_B1:    rval = cfg_reg.b1;
            shx_pkg::REG_A1:    rval = cfg_reg.a1;
            shx_pkg::REG_A2:    rval = cfg_reg.a2;
            shx_pkg::REG_COMB:  rval = cfg_reg.comb;
            shx_pkg::REG_GAIN:  rval = cfg_reg.gain;
            shx_pkg::REG_SCALE: rval = cfg_reg.scale;
            default:            rval = '0;
        endcase
        prdata = 32'(rval);
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/stereo_harmonic_saturator_eq.sv
// Each result takes 44 MAC steps, run one after another on the single shared digit-serial MAC;
//   every step has a load state, four 8-bit digits per product, a wait until the MAC is
//   idle, and a finish state.
// A new input is taken once the previous pair is handed to the output register.
// Reset (rst_n, async, active low) clears weights, filter histories and control;
//   the coefficient registers return to their default values.
module stereo_harmonic_saturator_eq
#(
    parameter int  SAMPLE_WIDTH = shx_pkg::SAMPLE_WIDTH_DEF,
    localparam int S_TDATA_W    = ((2 * SAMPLE_WIDTH + 21 + 7) / 8) * 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // left_sample, right_sample, third_left_on, third_right_on,
    // fifth_left_on, fifth_right_on, ramp_weight
    input  logic [S_TDATA_W-1:0]         s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // left_out, right_out
    output logic [47:0]                  m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [shx_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    `include "assert_macros.svh"

    localparam int SW = SAMPLE_WIDTH;

    shx_pkg::cfg_t     cfg;
    shx_pkg::mac_cmd_t mac_cmd;
    logic              mac_busy;
    logic signed [shx_pkg::ACC_W-1:0] acc;

    shx_pkg::state_t state_reg, state_next;
    logic [5:0]      step_reg;

    logic signed [SW-1:0]  left_reg, right_reg;
    logic [3:0]            tgt_reg;
    logic [shx_pkg::W_W-1:0] ramp_reg;
    logic [shx_pkg::W_W-1:0] w_l3_reg, w_r3_reg, w_l5_reg, w_r5_reg;

    logic signed [31:0] t_reg, t2_reg, t3_reg, t5_reg;
    logic signed [33:0] h3_reg, h5_reg;
    logic signed [35:0] dsum_reg;
    logic signed [31:0] d_reg, mix_reg, bp_reg, o_reg;
    logic signed [31:0] cl0_reg, cl1_reg, cr0_reg, cr1_reg;
    logic signed [31:0] il0_reg, il1_reg, ir0_reg, ir1_reg;
    logic signed [31:0] ol0_reg, ol1_reg, or0_reg, or1_reg;
    logic signed [shx_pkg::OUT_W-1:0] res_l_reg, res_r_reg;
    logic        [47:0] m_tdata_reg;
    logic               m_tvalid_reg;

    logic               ch;
    logic [5:0]         j_full;
    shx_pkg::op_t       op;
    logic [1:0]         g;
    logic [shx_pkg::W_W-1:0] w_cur, w3, w5;
    logic signed [31:0] x_c0, x_c1, i_c0, i_c1, o_c0, o_c1, x_in;
    logic signed [shx_pkg::OPA_W-1:0] op_a;
    logic signed [shx_pkg::OPB_W-1:0] op_b;
    logic               first, neg;

    logic signed [shx_pkg::ACC_W-1:0] r16, r20, r22;
    logic signed [shx_pkg::ACC_W-1:0] wsum, apsum;
    logic [shx_pkg::W_W-1:0] w_next;
    logic signed [31:0]  ap_next, mix_next, bp_next;
    logic [shx_pkg::W_W-1:0] ramp_in;

    shx_apb u_apb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shx_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .a     (op_a),
        .b     (op_b),
        .busy  (mac_busy),
        .acc   (acc)
    );

    assign ramp_in = (s_tdata[2*SW+20:2*SW+4] > shx_pkg::W_ONE) ? shx_pkg::W_ONE
                                                               : s_tdata[2*SW+20:2*SW+4];

    // Operand selection per channel and per glide step, and MAC command
    always_comb
    begin
        ch     = (step_reg >= shx_pkg::R_BASE);
        j_full = step_reg - (ch ? shx_pkg::R_BASE : shx_pkg::N_GLIDE);
        op     = shx_pkg::op_t'(j_full[4:0]);
        g      = step_reg[1:0];
        x_in   = ch ? 32'(right_reg) : 32'(left_reg);
        w3     = ch ? w_r3_reg : w_l3_reg;
        w5     = ch ? w_r5_reg : w_l5_reg;
        x_c0   = ch ? cr0_reg : cl0_reg;
        x_c1   = ch ? cr1_reg : cl1_reg;
        i_c0   = ch ? ir0_reg : il0_reg;
        i_c1   = ch ? ir1_reg : il1_reg;
        o_c0   = ch ? or0_reg : ol0_reg;
        o_c1   = ch ? or1_reg : ol1_reg;
        case (g)
            2'd0:    w_cur = w_l3_reg;
            2'd1:    w_cur = w_r3_reg;
            2'd2:    w_cur = w_l5_reg;
            default: w_cur = w_r5_reg;
        endcase

        first = 1'b1;
        neg   = 1'b0;
        op_a  = '0;
        op_b  = '0;
        if (step_reg < shx_pkg::N_GLIDE)
        begin
            op_a = (tgt_reg[g] ? 36'(shx_pkg::W_ONE) : 36'sd0) - 36'(w_cur);
            op_b = 32'(ramp_reg);
        end
        else
        begin
            case (op)
                shx_pkg::OP_T:     begin op_a = 36'(x_in);   op_b = shx_pkg::K_T; end
                shx_pkg::OP_T2:    begin op_a = 36'(t_reg);  op_b = t_reg; end
                shx_pkg::OP_T3:    begin op_a = 36'(t2_reg); op_b = t_reg; end
                shx_pkg::OP_T5:    begin op_a = 36'(t3_reg); op_b = t2_reg; end
                shx_pkg::OP_H3A:   begin op_a = 36'(t_reg);  op_b = shx_pkg::K_3B; end
                shx_pkg::OP_H3B:
                begin
                    op_a = 36'(t3_reg); op_b = shx_pkg::K_3A; first = 1'b0; neg = 1'b1;
                end
                shx_pkg::OP_H5A:   begin op_a = 36'(t5_reg); op_b = shx_pkg::K_5A; end
                shx_pkg::OP_H5B:
                begin
                    op_a = 36'(t3_reg); op_b = shx_pkg::K_5B; first = 1'b0; neg = 1'b1;
                end
                shx_pkg::OP_H5C:
                begin
                    op_a = 36'(t_reg); op_b = shx_pkg::K_5C; first = 1'b0;
                end
                shx_pkg::OP_LIN:   begin op_a = 36'(t_reg);  op_b = shx_pkg::K_LIN; end
                shx_pkg::OP_W3:    begin op_a = 36'(h3_reg); op_b = 32'(w3); end
                shx_pkg::OP_W5:    begin op_a = 36'(h5_reg); op_b = 32'(w5); end
                shx_pkg::OP_COMB:
                begin
                    op_a = 36'(x_c0) + 36'(x_c1); op_b = 32'(cfg.comb);
                end
                shx_pkg::OP_BP0:   begin op_a = 36'(mix_reg); op_b = 32'(cfg.b0); end
                shx_pkg::OP_BP1:
                begin
                    op_a = 36'(i_c0); op_b = 32'(cfg.b1); first = 1'b0;
                end
                shx_pkg::OP_BP2:
                begin
                    op_a = 36'(i_c1); op_b = 32'(cfg.b0); first = 1'b0;
                end
                shx_pkg::OP_BP3:
                begin
                    op_a = 36'(o_c0); op_b = 32'(cfg.a1); first = 1'b0; neg = 1'b1;
                end
                shx_pkg::OP_BP4:
                begin
                    op_a = 36'(o_c1); op_b = 32'(cfg.a2); first = 1'b0; neg = 1'b1;
                end
                shx_pkg::OP_GAIN:  begin op_a = 36'(bp_reg); op_b = 32'(cfg.gain); end
                shx_pkg::OP_SCALE: begin op_a = 36'(o_reg);  op_b = 32'(cfg.scale); end
                default: ;
            endcase
        end
        mac_cmd.start = (state_reg == shx_pkg::ST_LOAD);
        mac_cmd.clear = first;
        mac_cmd.neg   = neg;
    end

    // Finish values taken from the accumulator
    always_comb
    begin
        r16      = shx_pkg::rnd_sh(acc, 16);
        r20      = shx_pkg::rnd_sh(acc, 20);
        r22      = shx_pkg::rnd_sh(acc, 22);
        wsum     = 72'(w_cur) + r16;
        if (wsum < 72'sd0)
            w_next = '0;
        else if (wsum > 72'(shx_pkg::W_ONE))
            w_next = shx_pkg::W_ONE;
        else
            w_next = wsum[shx_pkg::W_W-1:0];
        ap_next  = shx_pkg::sat32(72'(d_reg) - r22);
        apsum    = (72'(ap_next) + 72'(d_reg) + 72'sd1) >>> 1;
        mix_next = apsum[31:0];
        bp_next  = shx_pkg::sat32(r22);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            shx_pkg::ST_IDLE: if (s_tvalid) state_next = shx_pkg::ST_LOAD;
            shx_pkg::ST_LOAD: state_next = shx_pkg::ST_MUL;
            shx_pkg::ST_MUL:  if (!mac_busy) state_next = shx_pkg::ST_FIN;
            shx_pkg::ST_FIN:
                state_next = (step_reg == shx_pkg::LAST_STEP) ? shx_pkg::ST_OUT
                                                                : shx_pkg::ST_LOAD;
            shx_pkg::ST_OUT:  if (!m_tvalid_reg || m_tready) state_next = shx_pkg::ST_IDLE;
            default:          state_next = shx_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= shx_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            w_l3_reg <= '0; w_r3_reg <= '0; w_l5_reg <= '0; w_r5_reg <= '0;
            cl0_reg  <= '0; cl1_reg  <= '0; cr0_reg  <= '0; cr1_reg  <= '0;
            il0_reg  <= '0; il1_reg  <= '0; ir0_reg  <= '0; ir1_reg  <= '0;
            ol0_reg  <= '0; ol1_reg  <= '0; or0_reg  <= '0; or1_reg  <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != shx_pkg::ST_OUT)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                shx_pkg::ST_IDLE:
                    if (s_tvalid)
                        step_reg <= '0;
                shx_pkg::ST_FIN:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg < shx_pkg::N_GLIDE)
                    begin
                        case (g)
                            2'd0:    w_l3_reg <= w_next;
                            2'd1:    w_r3_reg <= w_next;
                            2'd2:    w_l5_reg <= w_next;
                            default: w_r5_reg <= w_next;
                        endcase
                    end
                    else if (op == shx_pkg::OP_COMB)
                    begin
                        if (ch)
                        begin
                            cr1_reg <= cr0_reg; cr0_reg <= ap_next;
                        end
                        else
                        begin
                            cl1_reg <= cl0_reg; cl0_reg <= ap_next;
                        end
                    end
                    else if (op == shx_pkg::OP_BP4)
                    begin
                        if (ch)
                        begin
                            ir1_reg <= ir0_reg; ir0_reg <= mix_reg;
                            or1_reg <= or0_reg; or0_reg <= bp_next;
                        end
                        else
                        begin
                            il1_reg <= il0_reg; il0_reg <= mix_reg;
                            ol1_reg <= ol0_reg; ol0_reg <= bp_next;
                        end
                    end
                end
                shx_pkg::ST_OUT:
                    if (!m_tvalid_reg || m_tready)
                        m_tvalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == shx_pkg::ST_IDLE && s_tvalid)
        begin
            left_reg  <= s_tdata[SW-1:0];
            right_reg <= s_tdata[2*SW-1:SW];
            tgt_reg   <= s_tdata[2*SW+3:2*SW];
            ramp_reg  <= ramp_in;
        end
        if (state_reg == shx_pkg::ST_OUT && (!m_tvalid_reg || m_tready))
            m_tdata_reg <= {4'b0000, res_r_reg, res_l_reg};
        if (state_reg == shx_pkg::ST_FIN && step_reg >= shx_pkg::N_GLIDE)
        begin
            case (op)
                shx_pkg::OP_T:     t_reg    <= shx_pkg::sat32(r22);
                shx_pkg::OP_T2:    t2_reg   <= shx_pkg::sat32(r20);
                shx_pkg::OP_T3:    t3_reg   <= shx_pkg::sat32(r20);
                shx_pkg::OP_T5:    t5_reg   <= shx_pkg::sat32(r20);
                shx_pkg::OP_H3B:   h3_reg   <= r22[33:0];
                shx_pkg::OP_H5C:   h5_reg   <= r22[33:0];
                shx_pkg::OP_LIN:   dsum_reg <= r22[35:0];
                shx_pkg::OP_W3:    dsum_reg <= dsum_reg + r16[35:0];
                shx_pkg::OP_W5:    d_reg    <= shx_pkg::sat32(72'(dsum_reg) + r16);
                shx_pkg::OP_COMB:  mix_reg  <= mix_next;
                shx_pkg::OP_BP4:   bp_reg   <= bp_next;
                shx_pkg::OP_GAIN:  o_reg    <= shx_pkg::sat32(72'(d_reg) + r22);
                shx_pkg::OP_SCALE:
                begin
                    if (ch)
                        res_r_reg <= shx_pkg::sat_out(r22);
                    else
                        res_l_reg <= shx_pkg::sat_out(r22);
                end
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == shx_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SHX_ASSERT(a_start_seq, (s_tvalid && s_tready) |=> (state_reg == shx_pkg::ST_LOAD) && (step_reg == 6'd0), "sequence did not start at step zero")
    `SHX_ASSERT(a_out_step, (state_reg == shx_pkg::ST_OUT) |-> (step_reg == shx_pkg::LAST_STEP + 6'd1), "result stage reached before last step")
    `SHX_ASSERT(a_w_range, (w_l3_reg <= shx_pkg::W_ONE) && (w_r3_reg <= shx_pkg::W_ONE) && (w_l5_reg <= shx_pkg::W_ONE) && (w_r5_reg <= shx_pkg::W_ONE), "harmonic weight out of range")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the stereo harmonic saturator: stream stimulus, APB setup, predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int SW = shx_pkg::SAMPLE_WIDTH_DEF;
    localparam int IN_W = ((2 * SW + 21 + 7) / 8) * 8;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 830;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [47:0] m_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [shx_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    stereo_harmonic_saturator_eq u_top (.*);

    // predictor state
    longint coef [7];
    longint glide_w [4];
    longint comb_hist [4];
    longint bin_hist [4];
    longint bout_hist [4];

    logic [IN_W-1:0] pending_pairs [$];
    logic [47:0] expected_outs [$];
    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit tx_quiet;
    bit rx_quiet;
    int tx_gap;
    int rx_gap;

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim - 1)
            return -lim - 1;
        return v;
    endfunction

    function automatic longint clip32(longint v);
        return clip(v, 64'sd2147483647);
    endfunction

    function automatic void glide_toward(int idx, bit on, longint ramp);
        longint tgt;
        longint w;
        tgt = on ? 65536 : 0;
        w = glide_w[idx] + round_sh(ramp * (tgt - glide_w[idx]), 16);
        if (w < 0)
            w = 0;
        if (w > 65536)
            w = 65536;
        glide_w[idx] = w;
    endfunction

    function automatic longint saturate_channel(longint x, longint w3, longint w5, int b);
        longint t, t2, t3, t5, h3, h5, d, ap, mix, bp, o;
        t = clip32(round_sh(2995931 * x, 22));
        t2 = clip32(round_sh(t * t, 20));
        t3 = clip32(round_sh(t * t2, 20));
        t5 = clip32(round_sh(t3 * t2, 20));
        h3 = round_sh(1461083 * t - 1948110 * t3, 22);
        h5 = round_sh(1439651 * t5 - 1799564 * t3 + 449891 * t, 22);
        d = clip32(round_sh(4512289 * t, 22) + round_sh(w3 * h3, 16) + round_sh(w5 * h5, 16));
        ap = clip32(d - round_sh(coef[shx_pkg::REG_COMB] * (comb_hist[b] + comb_hist[b + 1]),
                                 22));
        comb_hist[b + 1] = comb_hist[b];
        comb_hist[b] = ap;
        mix = round_sh(ap + d, 1);
        bp = coef[shx_pkg::REG_B0] * mix + coef[shx_pkg::REG_B1] * bin_hist[b]
            + coef[shx_pkg::REG_B0] * bin_hist[b + 1]
            - coef[shx_pkg::REG_A1] * bout_hist[b] - coef[shx_pkg::REG_A2] * bout_hist[b + 1];
        bp = clip32(round_sh(bp, 22));
        bin_hist[b + 1] = bin_hist[b];
        bin_hist[b] = mix;
        bout_hist[b + 1] = bout_hist[b];
        bout_hist[b] = bp;
        o = clip32(d + round_sh(coef[shx_pkg::REG_GAIN] * bp, 22));
        o = round_sh(coef[shx_pkg::REG_SCALE] * o, 22);
        return clip(o, 1101004);
    endfunction

    function automatic logic [47:0] predict_pair(logic [IN_W-1:0] v);
        longint l, r, ramp, lo, ro;
        logic [47:0] res;
        l = longint'($signed(v[SW-1:0]));
        r = longint'($signed(v[2*SW-1:SW]));
        ramp = longint'(v[2*SW+4 +: 17]);
        if (ramp > 65536)
            ramp = 65536;
        for (int i = 0; i < 4; i++)
            glide_toward(i, v[2*SW+i], ramp);
        lo = saturate_channel(l, glide_w[0], glide_w[2], 0);
        ro = saturate_channel(r, glide_w[1], glide_w[3], 2);
        res = '0;
        res[21:0] = lo[21:0];
        res[43:22] = ro[21:0];
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_pair(logic [SW-1:0] l, logic [SW-1:0] r,
                                                  logic [3:0] en, logic [16:0] ramp);
        logic [IN_W-1:0] v;
        v = '0;
        v[SW-1:0] = l;
        v[2*SW-1:SW] = r;
        v[2*SW +: 4] = en;
        v[2*SW+4 +: 17] = ramp;
        return v;
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            2: return SW'($signed($urandom_range(0, 2097152)) - 1048576);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_ramp();
        case ($urandom_range(0, 4))
            0: return 17'd65536;
            1: return 17'($urandom_range(65537, 131071));
            2: return 17'd0;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            tx_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (tx_gap > 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_pairs.pop_front();
                if (!tx_quiet && $urandom_range(0, 3) == 0)
                    tx_gap <= $urandom_range(1, 14);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // predict at the input transfer
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            expected_outs.push_back(predict_pair(s_tdata));
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_outs.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h", m_tdata);
                end
                else
                begin
                    logic [47:0] e;
                    e = expected_outs.pop_front();
                    if (e[21:0] !== m_tdata[21:0] || e[43:22] !== m_tdata[43:22])
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
                                     $signed(e[21:0]), $signed(m_tdata[21:0]),
                                     $signed(e[43:22]), $signed(m_tdata[43:22]));
                    end
                end
            end
            if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end
            else if (!rx_quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                rx_gap <= $urandom_range(0, 13);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic signed [shx_pkg::CFG_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= shx_pkg::PADDR_W'({idx, 2'b00});
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        coef[idx] = longint'(val);
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || s_tvalid || expected_outs.size() > 0)
            @(posedge clk);
        repeat (320) @(posedge clk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            pending_pairs.push_back(pack_pair(rand_sample(), rand_sample(),
                                              4'($urandom), rand_ramp()));
    endtask

    initial
    begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        coef[shx_pkg::REG_B0] = shx_pkg::RST_B0;
        coef[shx_pkg::REG_B1] = shx_pkg::RST_B1;
        coef[shx_pkg::REG_A1] = shx_pkg::RST_A1;
        coef[shx_pkg::REG_A2] = shx_pkg::RST_A2;
        coef[shx_pkg::REG_COMB] = shx_pkg::RST_COMB;
        coef[shx_pkg::REG_GAIN] = shx_pkg::RST_GAIN;
        coef[shx_pkg::REG_SCALE] = shx_pkg::RST_SCALE;
        for (int i = 0; i < 4; i++)
        begin
            glide_w[i] = 0;
            comb_hist[i] = 0;
            bin_hist[i] = 0;
            bout_hist[i] = 0;
        end
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, all enables, ramp zero, full and beyond
        pending_pairs.push_back(pack_pair('0, '0, 4'hF, 17'd65536));
        pending_pairs.push_back(pack_pair({1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}},
                                          4'hF, 17'd131071));
        pending_pairs.push_back(pack_pair({1'b1, {(SW-1){1'b0}}}, {1'b0, {(SW-1){1'b1}}},
                                          4'h0, 17'd0));
        pending_pairs.push_back(pack_pair(24'd1048576, -24'sd1048576, 4'h5, 17'd32768));
        pending_pairs.push_back(pack_pair(24'd1048576, -24'sd1048576, 4'hA, 17'd65537));
        pending_pairs.push_back(pack_pair(24'd1, -24'sd1, 4'h3, 17'd1));
        for (int i = 0; i < 14; i++)
            pending_pairs.push_back(pack_pair(rand_sample(), rand_sample(),
                                              4'(i), 17'd65536));
        wait_drained();

        // phase with extreme coefficients: clamp paths and saturation
        apb_write(shx_pkg::REG_B0, 24'sh7FFFFF);
        apb_write(shx_pkg::REG_B1, 24'sh800000);
        apb_write(shx_pkg::REG_A1, 24'sh7FFFFF);
        apb_write(shx_pkg::REG_A2, 24'sh800000);
        apb_write(shx_pkg::REG_COMB, 24'sh800000);
        apb_write(shx_pkg::REG_GAIN, 24'sh7FFFFF);
        apb_write(shx_pkg::REG_SCALE, 24'sh800000);
        queue_random(200);
        wait_drained();

        // random coefficients
        for (int i = 0; i < shx_pkg::N_REGS; i++)
            apb_write(3'(i), 24'($urandom));
        queue_random(200);
        wait_drained();

        // back to defaults, quiet stretch at the end
        apb_write(shx_pkg::REG_B0, shx_pkg::RST_B0);
        apb_write(shx_pkg::REG_B1, shx_pkg::RST_B1);
        apb_write(shx_pkg::REG_A1, shx_pkg::RST_A1);
        apb_write(shx_pkg::REG_A2, shx_pkg::RST_A2);
        apb_write(shx_pkg::REG_COMB, shx_pkg::RST_COMB);
        apb_write(shx_pkg::REG_GAIN, shx_pkg::RST_GAIN);
        apb_write(shx_pkg::REG_SCALE, shx_pkg::RST_SCALE);
        queue_random(N_RANDOM - 400);
        while (pending_pairs.size() > 100)
            @(posedge clk);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        wait_drained();

        $display("covered %0d stereo pairs over four coefficient sets, extremes included",
                 results_seen);
        if (mismatches == 0 && expected_outs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
